@@ design/assert_macros.svh @@
// Assertion macros shared by the vector field smoothing engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VFSE_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define VFSE_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define VFSE_ASSERT(label, clk, rstn, prop)
`define VFSE_NEVER(label, clk, rstn, expr)
`endif
`endif

@@ design/vfse_pkg.sv @@
// Types, constants and helper functions of the vector field smoothing engine.
package vfse_pkg;

    localparam int COL_W     = 6;
    localparam int ROW_W     = 6;
    localparam int ADDR_W    = COL_W + ROW_W;
    localparam int DIM_W     = 7;
    localparam int COMP_W    = 16;
    localparam int MAG_W     = 16;
    localparam int SQ_W      = 32;
    localparam int SQ_STEPS  = 16;
    localparam int ACC_W     = 40;
    localparam int SM_W      = 20;
    localparam int Q_W       = 35;
    localparam int DIV_STEPS = Q_W;
    localparam int CELLS     = 1 << ADDR_W;

    localparam logic [DIM_W-1:0]  MAX_WIDTH    = 7'd64;
    localparam logic [DIM_W-1:0]  MAX_HEIGHT   = 7'd64;
    localparam logic [15:0]       INV_SQRT2_Q16 = 16'd46341;
    localparam logic              CFG_WIDTH    = 1'b0;
    localparam logic              CFG_HEIGHT   = 1'b1;
    localparam logic              STATUS_DONE    = 1'b0;
    localparam logic              STATUS_OUTSIDE = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_STEP  = 2'd2,
        OP_WELL  = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_WR, S_RD, S_WMUL, S_WNB,
        S_SCELL, S_NBRD, S_SQLD, S_SQINIT, S_SQ, S_ACC, S_DIVI, S_DIV, S_SWR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic clr_wr;
        logic cell_clr;
        logic cell_adv;
        logic latch_in;
        logic wr_cell;
        logic rd_cell;
        logic well_mul;
        logic well_wr;
        logic nb_clr;
        logic nb_rd;
        logic nb_adv;
        logic sq_load;
        logic sq_init;
        logic sq_step;
        logic acc_clr;
        logic acc;
        logic div_init;
        logic div_step;
        logic step_wr;
        logic flip;
        logic load_out;
    } vfse_cmd_t;

    typedef struct packed {
        logic cell_last;
        logic in_grid;
        op_t  op;
        logic nb_last;
        logic sq_last;
        logic div_last;
        logic out_free;
    } vfse_sts_t;

    function automatic logic [COMP_W-1:0] sat17(input logic signed [COMP_W:0] v);
        logic [COMP_W-1:0] r;
        if (v > 17'sd32767) begin
            r = 16'h7FFF;
        end else if (v < -17'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[COMP_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [COMP_W-1:0] div_sat(input logic [Q_W-1:0] q, input logic neg);
        logic [COMP_W-1:0] r;
        if (!neg) begin
            r = (q > Q_W'(32767)) ? 16'h7FFF : q[COMP_W-1:0];
        end else begin
            r = (q > Q_W'(32768)) ? 16'h8000 : 16'(16'd0 - q[COMP_W-1:0]);
        end
        return r;
    endfunction

endpackage

@@ design/vector_field_smoothing_engine.sv @@
// Top level of the vector field smoothing engine: controller, datapath and checks.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid/s_ready    s_op s_col s_row s_vec_x s_vec_y s_well_force
//  m_       out        m_valid/m_ready    m_out_x m_out_y m_status
//  cfg_     in         cfg_wr_en          cfg_index cfg_wr_data
//
// A step smooths every cell: per cell nine neighbours each pass through a square
// root, then a divider, all over the single read port of a bank. After reset a
// clearing pass over every cell zeroes bank a before s_ready rises. One beat is
// in work at a time; a result waiting in the output register does not hold off
// the next input beat.
`include "assert_macros.svh"
module vector_field_smoothing_engine import vfse_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_index,
    input  logic [DIM_W-1:0]         cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_op,
    input  logic [COL_W-1:0]         s_col,
    input  logic [ROW_W-1:0]         s_row,
    input  logic signed [COMP_W-1:0] s_vec_x,
    input  logic signed [COMP_W-1:0] s_vec_y,
    input  logic signed [COMP_W-1:0] s_well_force,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [COMP_W-1:0] m_out_x,
    output logic signed [COMP_W-1:0] m_out_y,
    output logic                     m_status
);

    vfse_cmd_t cmd;
    vfse_sts_t sts;

    vfse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    vfse_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_op         (s_op),
        .s_col        (s_col),
        .s_row        (s_row),
        .s_vec_x      (s_vec_x),
        .s_vec_y      (s_vec_y),
        .s_well_force (s_well_force),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_out_x      (m_out_x),
        .m_out_y      (m_out_y),
        .m_status     (m_status)
    );

    `VFSE_ASSERT(a_one_beat_in_work, aclk, aresetn, (s_valid && s_ready) |=> !s_ready)
    `VFSE_NEVER(a_outside_gives_zero, aclk, aresetn, m_valid && m_status && (m_out_x | m_out_y) != '0)
    `VFSE_ASSERT(a_single_writer, aclk, aresetn, $onehot0({cmd.clr_wr, cmd.wr_cell, cmd.well_wr, cmd.step_wr}))

endmodule

@@ design/vfse_datapath.sv @@
// Datapath: grid banks, neighbour addressing, square root, accumulators and divider.
module vfse_datapath import vfse_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  vfse_cmd_t                cmd,
    output vfse_sts_t                sts,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_index,
    input  logic [DIM_W-1:0]         cfg_wr_data,
    input  logic [1:0]               s_op,
    input  logic [COL_W-1:0]         s_col,
    input  logic [ROW_W-1:0]         s_row,
    input  logic signed [COMP_W-1:0] s_vec_x,
    input  logic signed [COMP_W-1:0] s_vec_y,
    input  logic signed [COMP_W-1:0] s_well_force,
    input  logic                     m_ready,
    output logic                     m_valid,
    output logic signed [COMP_W-1:0] m_out_x,
    output logic signed [COMP_W-1:0] m_out_y,
    output logic                     m_status
);

    logic [DIM_W-1:0]         cfg_w_reg, cfg_h_reg, w_eff, h_eff;
    op_t                      op_reg;
    logic [COL_W-1:0]         col_reg;
    logic [ROW_W-1:0]         row_reg;
    logic [COMP_W-1:0]        vx_reg, vy_reg;
    logic signed [COMP_W-1:0] force_reg;
    logic                     cur_reg;
    logic [ADDR_W-1:0]        cell_reg;
    logic [1:0]               nbr_reg, nbc_reg;
    logic [3:0]               sq_cnt_reg;
    logic [5:0]               div_cnt_reg;

    logic [31:0]              mem_a [CELLS];
    logic [31:0]              mem_b [CELLS];
    logic [31:0]              rd_a_reg, rd_b_reg, rd_data, wd;
    logic [ADDR_W-1:0]        wa, ra;
    logic                     we_a, we_b, re;

    logic                     step_mode, centre_ok, nb_ok, ok_reg;
    logic [ROW_W-1:0]         base_row;
    logic [COL_W-1:0]         base_col;
    logic [7:0]               nr, nc;
    logic [ADDR_W-1:0]        nb_addr;

    logic [COMP_W-1:0]        diag_reg;
    logic [COMP_W:0]          force_mag;
    logic [33:0]              diag_prod;
    logic signed [COMP_W:0]   s_val, neg_s;
    logic [COMP_W-1:0]        well_x, well_y;

    logic signed [COMP_W-1:0] x_reg, y_reg;
    logic signed [31:0]       sqx_full, sqy_full;
    logic [SQ_W-1:0]          sq_n_reg, sq_res_reg, sq_bit_reg;
    logic [SQ_W:0]            sq_trial;
    logic signed [32:0]       px, py;
    logic signed [ACC_W-1:0]  sx_reg, sy_reg;
    logic [SM_W-1:0]          sm_reg;
    logic [ACC_W-1:0]         ax, ay;
    logic                     negx_reg, negy_reg;
    logic [Q_W-1:0]           qx_reg, qy_reg;
    logic [SM_W-1:0]          remx_reg, remy_reg;
    logic [SM_W:0]            rsx, rsy;
    logic                     gex, gey;
    logic [COMP_W-1:0]        rx, ry;

    always_comb begin
        w_eff = (cfg_w_reg == '0) ? DIM_W'(1) : ((cfg_w_reg > MAX_WIDTH) ? MAX_WIDTH : cfg_w_reg);
        h_eff = (cfg_h_reg == '0) ? DIM_W'(1) : ((cfg_h_reg > MAX_HEIGHT) ? MAX_HEIGHT : cfg_h_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg <= MAX_WIDTH;
            cfg_h_reg <= MAX_HEIGHT;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_WIDTH) begin
                cfg_w_reg <= cfg_wr_data;
            end else begin
                cfg_h_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            op_reg    <= op_t'(s_op);
            col_reg   <= s_col;
            row_reg   <= s_row;
            vx_reg    <= s_vec_x;
            vy_reg    <= s_vec_y;
            force_reg <= s_well_force;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg     <= 1'b0;
            cell_reg    <= '0;
            nbr_reg     <= '0;
            nbc_reg     <= '0;
            sq_cnt_reg  <= '0;
            div_cnt_reg <= '0;
        end else begin
            if (cmd.flip) begin
                cur_reg <= ~cur_reg;
            end
            if (cmd.cell_clr) begin
                cell_reg <= '0;
            end else if (cmd.cell_adv) begin
                cell_reg <= cell_reg + 1'b1;
            end
            if (cmd.nb_clr) begin
                nbr_reg <= '0;
                nbc_reg <= '0;
            end else if (cmd.nb_adv) begin
                if (nbc_reg == 2'd2) begin
                    nbc_reg <= '0;
                    nbr_reg <= nbr_reg + 1'b1;
                end else begin
                    nbc_reg <= nbc_reg + 1'b1;
                end
            end
            if (cmd.sq_init) begin
                sq_cnt_reg <= '0;
            end else if (cmd.sq_step) begin
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
            end
            if (cmd.div_init) begin
                div_cnt_reg <= '0;
            end else if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
        end
    end

    // Neighbour coordinates around the addressed cell or the cell being smoothed.
    always_comb begin
        step_mode = (op_reg == OP_STEP);
        base_row  = step_mode ? cell_reg[ADDR_W-1:COL_W] : row_reg;
        base_col  = step_mode ? cell_reg[COL_W-1:0] : col_reg;
        nr        = {2'b00, base_row} + {6'd0, nbr_reg} - 8'd1;
        nc        = {2'b00, base_col} + {6'd0, nbc_reg} - 8'd1;
        centre_ok = ({1'b0, base_row} < h_eff) && ({1'b0, base_col} < w_eff);
        nb_ok     = !nr[7] && !nc[7] && (nr[6:0] < h_eff) && (nc[6:0] < w_eff)
                    && centre_ok
                    && !(!step_mode && nbr_reg == 2'd1 && nbc_reg == 2'd1);
        nb_addr   = {nr[ROW_W-1:0], nc[COL_W-1:0]};
    end

    always_comb begin
        force_mag = force_reg[COMP_W-1] ? 17'(-{force_reg[COMP_W-1], force_reg})
                                        : {1'b0, force_reg};
        diag_prod = 34'(force_mag) * 34'(INV_SQRT2_Q16) + 34'd32768;
        s_val     = (nbr_reg != 2'd1 && nbc_reg != 2'd1)
                    ? (force_reg[COMP_W-1] ? -$signed({1'b0, diag_reg})
                                           : $signed({1'b0, diag_reg}))
                    : $signed({force_reg[COMP_W-1], force_reg});
        neg_s     = -s_val;
        well_x    = (nbc_reg == 2'd1) ? '0 : sat17((nbc_reg == 2'd0) ? s_val : neg_s);
        well_y    = (nbr_reg == 2'd1) ? '0 : sat17((nbr_reg == 2'd0) ? s_val : neg_s);
    end

    always_ff @(posedge aclk) begin
        if (cmd.well_mul) begin
            diag_reg <= diag_prod[31:16];
        end
    end

    always_comb begin
        we_a = 1'b0;
        we_b = 1'b0;
        wa   = cell_reg;
        wd   = '0;
        if (cmd.clr_wr) begin
            we_a = 1'b1;
        end else if (cmd.wr_cell) begin
            we_a = !cur_reg;
            we_b = cur_reg;
            wa   = {row_reg, col_reg};
            wd   = {vy_reg, vx_reg};
        end else if (cmd.well_wr) begin
            we_a = nb_ok && !cur_reg;
            we_b = nb_ok && cur_reg;
            wa   = nb_addr;
            wd   = {well_y, well_x};
        end else if (cmd.step_wr) begin
            we_a = cur_reg;
            we_b = !cur_reg;
            wd   = {ry, rx};
        end
        re      = cmd.rd_cell || cmd.nb_rd;
        ra      = cmd.rd_cell ? {row_reg, col_reg} : nb_addr;
        rd_data = cur_reg ? rd_b_reg : rd_a_reg;
    end

    always_ff @(posedge aclk) begin
        if (we_a) begin
            mem_a[wa] <= wd;
        end
        if (re) begin
            rd_a_reg <= mem_a[ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (we_b) begin
            mem_b[wa] <= wd;
        end
        if (re) begin
            rd_b_reg <= mem_b[ra];
        end
    end

    // Magnitude by digit-by-digit square root, two bits of the radicand per cycle.
    always_comb begin
        sqx_full = x_reg * x_reg;
        sqy_full = y_reg * y_reg;
        sq_trial = {1'b0, sq_res_reg} + {1'b0, sq_bit_reg};
        px       = x_reg * $signed({1'b0, sq_res_reg[MAG_W-1:0]});
        py       = y_reg * $signed({1'b0, sq_res_reg[MAG_W-1:0]});
        ax       = sx_reg[ACC_W-1] ? ACC_W'(-sx_reg) : ACC_W'(sx_reg);
        ay       = sy_reg[ACC_W-1] ? ACC_W'(-sy_reg) : ACC_W'(sy_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.nb_rd) begin
            ok_reg <= nb_ok;
        end
        if (cmd.sq_load) begin
            x_reg <= ok_reg ? rd_data[15:0] : '0;
            y_reg <= ok_reg ? rd_data[31:16] : '0;
        end
        if (cmd.sq_init) begin
            sq_n_reg   <= {1'b0, sqx_full[30:0]} + {1'b0, sqy_full[30:0]};
            sq_res_reg <= '0;
            sq_bit_reg <= SQ_W'(1) << (SQ_W - 2);
        end else if (cmd.sq_step) begin
            if ({1'b0, sq_n_reg} >= sq_trial) begin
                sq_n_reg   <= sq_n_reg - sq_trial[SQ_W-1:0];
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
            end else begin
                sq_res_reg <= sq_res_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
        if (cmd.acc_clr) begin
            sx_reg <= '0;
            sy_reg <= '0;
            sm_reg <= '0;
        end else if (cmd.acc) begin
            sx_reg <= sx_reg + ACC_W'(px);
            sy_reg <= sy_reg + ACC_W'(py);
            sm_reg <= sm_reg + SM_W'(sq_res_reg[MAG_W-1:0]);
        end
    end

    // Restoring division of both magnitudes by the weight sum, one quotient bit a cycle.
    always_comb begin
        rsx = {remx_reg, qx_reg[Q_W-1]};
        rsy = {remy_reg, qy_reg[Q_W-1]};
        gex = rsx >= {1'b0, sm_reg};
        gey = rsy >= {1'b0, sm_reg};
        rx  = (sm_reg == '0) ? '0 : div_sat(qx_reg, negx_reg);
        ry  = (sm_reg == '0) ? '0 : div_sat(qy_reg, negy_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            negx_reg <= sx_reg[ACC_W-1];
            negy_reg <= sy_reg[ACC_W-1];
            qx_reg   <= Q_W'(ax + ACC_W'(sm_reg >> 1));
            qy_reg   <= Q_W'(ay + ACC_W'(sm_reg >> 1));
            remx_reg <= '0;
            remy_reg <= '0;
        end else if (cmd.div_step) begin
            remx_reg <= gex ? SM_W'(rsx - {1'b0, sm_reg}) : rsx[SM_W-1:0];
            remy_reg <= gey ? SM_W'(rsy - {1'b0, sm_reg}) : rsy[SM_W-1:0];
            qx_reg   <= {qx_reg[Q_W-2:0], gex};
            qy_reg   <= {qy_reg[Q_W-2:0], gey};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            if (op_reg == OP_READ && sts.in_grid) begin
                m_out_x <= rd_data[15:0];
                m_out_y <= rd_data[31:16];
            end else begin
                m_out_x <= '0;
                m_out_y <= '0;
            end
            m_status <= (op_reg != OP_STEP && !sts.in_grid) ? STATUS_OUTSIDE : STATUS_DONE;
        end
    end

    always_comb begin
        sts.cell_last = (cell_reg == ADDR_W'(CELLS - 1));
        sts.in_grid   = ({1'b0, row_reg} < h_eff) && ({1'b0, col_reg} < w_eff);
        sts.op        = op_reg;
        sts.nb_last   = (nbr_reg == 2'd2) && (nbc_reg == 2'd2);
        sts.sq_last   = (sq_cnt_reg == 4'(SQ_STEPS - 1));
        sts.div_last  = (div_cnt_reg == 6'(DIV_STEPS - 1));
        sts.out_free  = !m_valid || m_ready;
    end

endmodule

@@ design/vfse_ctrl.sv @@
// Controller state machine that sequences every operation over the datapath.
module vfse_ctrl import vfse_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  vfse_sts_t sts,
    output vfse_cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr   = 1'b1;
                cmd.cell_adv = 1'b1;
                if (sts.cell_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready      = 1'b1;
                cmd.latch_in = s_valid;
                if (s_valid) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (sts.op == OP_STEP) begin
                    cmd.cell_clr = 1'b1;
                    state_next   = S_SCELL;
                end else if (!sts.in_grid) begin
                    state_next = S_DONE;
                end else if (sts.op == OP_WRITE) begin
                    state_next = S_WR;
                end else if (sts.op == OP_READ) begin
                    state_next = S_RD;
                end else begin
                    state_next = S_WMUL;
                end
            end
            S_WR: begin
                cmd.wr_cell = 1'b1;
                state_next  = S_DONE;
            end
            S_RD: begin
                cmd.rd_cell = 1'b1;
                state_next  = S_DONE;
            end
            S_WMUL: begin
                cmd.well_mul = 1'b1;
                cmd.nb_clr   = 1'b1;
                state_next   = S_WNB;
            end
            S_WNB: begin
                cmd.well_wr = 1'b1;
                cmd.nb_adv  = 1'b1;
                if (sts.nb_last) begin
                    state_next = S_DONE;
                end
            end
            S_SCELL: begin
                cmd.nb_clr  = 1'b1;
                cmd.acc_clr = 1'b1;
                state_next  = S_NBRD;
            end
            S_NBRD: begin
                cmd.nb_rd  = 1'b1;
                state_next = S_SQLD;
            end
            S_SQLD: begin
                cmd.sq_load = 1'b1;
                state_next  = S_SQINIT;
            end
            S_SQINIT: begin
                cmd.sq_init = 1'b1;
                state_next  = S_SQ;
            end
            S_SQ: begin
                cmd.sq_step = 1'b1;
                if (sts.sq_last) begin
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                cmd.acc    = 1'b1;
                cmd.nb_adv = 1'b1;
                state_next = sts.nb_last ? S_DIVI : S_NBRD;
            end
            S_DIVI: begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = S_SWR;
                end
            end
            S_SWR: begin
                cmd.step_wr  = 1'b1;
                cmd.cell_adv = 1'b1;
                if (sts.cell_last) begin
                    cmd.flip   = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_SCELL;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
